// File: hw/rtl/assert_macros.svh
// Assertion helpers for the frame pacer RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/fpoc_pkg.sv
package fpoc_pkg;

   // Field and state widths
   localparam int TIME_W   = 62;
   localparam int PERIOD_W = 40;
   localparam int OVER_W   = 42;
   localparam int CHECK_W  = 63;
   localparam int CALC_W   = 66;

   // Battery flag is resampled at most once per this many nanoseconds.
   localparam logic [CHECK_W-1:0] CHECK_INTERVAL = 63'd10_000_000_000;

   // Largest sleep that can be reported.
   localparam logic [PERIOD_W-1:0] SLEEP_MAX = 40'hFF_FFFF_FFFF;

   // Floor applied to a measured oversleep before it is stored.
   localparam logic signed [OVER_W-1:0] OVER_MIN = {1'b1, 41'd0};

   typedef enum logic [1:0] {
      ACT_DISABLED   = 2'd0,
      ACT_NO_SLEEP   = 2'd1,
      ACT_GRANT      = 2'd2,
      ACT_REPORT_ACK = 2'd3
   } action_type;

   typedef enum logic {
      MODE_REQUEST = 1'b0,
      MODE_REPORT  = 1'b1
   } mode_type;

   typedef enum logic {
      REG_PERIOD_MAINS   = 1'b0,
      REG_PERIOD_BATTERY = 1'b1
   } csr_index_type;

   // One oversleep sample headed for the history ring.
   typedef struct packed {
      logic                     push;
      logic signed [OVER_W-1:0] value;
   } ring_push_type;

endpackage

// File: hw/rtl/fpoc_ram.sv
module fpoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/fpoc_ring.sv
module fpoc_ring #(
   parameter int RING_DEPTH = 4,
   parameter int SUM_W      = 44
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fpoc_pkg::ring_push_type ring_push,
   output logic signed [SUM_W-1:0] sum_next
);

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int OVER_W = fpoc_pkg::OVER_W;

   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [RING_DEPTH-1:0]    valid_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [OVER_W-1:0]        rdata;
   logic signed [OVER_W-1:0] old_value;

   // Next write slot, wrapping at the ring depth.
   always_comb begin
      slot_in = slot_ff;
      if (ring_push.push) begin
         slot_in = (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
      end
   end

   // The read port addresses the next write slot, so the sample about to be
   // replaced is ready when the next push arrives.
   fpoc_ram #(
      .WIDTH (OVER_W),
      .DEPTH (RING_DEPTH)
   ) u_ring_ram (
      .clock (clock),
      .we    (ring_push.push),
      .waddr (slot_ff),
      .wdata (ring_push.value),
      .raddr (slot_in),
      .rdata (rdata)
   );

   // A slot that was never written counts as zero.
   assign old_value = valid_ff[slot_ff] ? $signed(rdata) : '0;

   // Running sum drops the oldest sample and adds the new one.
   always_comb begin
      sum_in = sum_ff;
      if (ring_push.push) begin
         sum_in = sum_ff - SUM_W'(old_value) + SUM_W'(ring_push.value);
      end
   end

   assign sum_next = sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= '0;
         sum_ff   <= '0;
      end else begin
         slot_ff <= slot_in;
         sum_ff  <= sum_in;
         if (ring_push.push) begin
            valid_ff[slot_ff] <= 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/fpoc_avg.sv
module fpoc_avg #(
   parameter int RING_DEPTH = 4,
   parameter int SUM_W      = 44
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] sum_next,
   output logic signed [SUM_W-1:0] avg,
   output logic                    busy
);

   logic signed [SUM_W-1:0] avg_ff;

   assign avg = avg_ff;

   generate
      if ((RING_DEPTH & (RING_DEPTH - 1)) == 0) begin : g_shift
         localparam int SHIFT = $clog2(RING_DEPTH);

         logic signed [SUM_W-1:0] bias;
         logic signed [SUM_W-1:0] biased;

         // Rounding toward zero: bias negative sums before the arithmetic shift.
         assign bias   = sum_next[SUM_W-1] ? SUM_W'(RING_DEPTH - 1) : '0;
         assign biased = sum_next + bias;
         assign busy   = 1'b0;

         always_ff @(posedge clock) begin
            if (reset) begin
               avg_ff <= '0;
            end else if (start) begin
               avg_ff <= biased >>> SHIFT;
            end
         end
      end else begin : g_divide
         localparam int STEPS   = 8;
         localparam int PAD_W   = ((SUM_W + STEPS - 1) / STEPS) * STEPS;
         localparam int N_CYC   = PAD_W / STEPS;
         localparam int CNT_W   = $clog2(N_CYC + 1);
         localparam int SHIFT_S = SUM_W + $clog2(RING_DEPTH);
         localparam int PROD_W  = PAD_W + SHIFT_S;
         localparam logic [63:0] RECIP_FULL =
            ((64'd1 << SHIFT_S) + 64'(RING_DEPTH - 1)) / 64'(RING_DEPTH);
         localparam logic [SHIFT_S-1:0] RECIP_M = RECIP_FULL[SHIFT_S-1:0];

         logic [PAD_W-1:0]           work_ff;
         logic [PROD_W-1:0]          acc_ff, acc_v;
         logic [STEPS+SHIFT_S-1:0]   part;
         logic [CNT_W-1:0]           cnt_ff;
         logic                       neg_ff;
         logic                       running_ff;
         logic [SUM_W-1:0]           mag;
         logic [SUM_W-1:0]           quot;

         // Magnitude of the sum; the sign is put back on the quotient.
         assign mag  = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
         assign busy = running_ff;

         // Multiply the magnitude by the rounded-up reciprocal of the ring
         // depth, eight bits per cycle from the top; the quotient is the
         // product shifted down.
         assign part  = work_ff[PAD_W-1 -: STEPS] * RECIP_M;
         assign acc_v = {acc_ff[PROD_W-STEPS-1:0], {STEPS{1'b0}}} + PROD_W'(part);
         assign quot  = acc_v[SHIFT_S +: SUM_W];

         always_ff @(posedge clock) begin
            if (reset) begin
               running_ff <= 1'b0;
               cnt_ff     <= '0;
               avg_ff     <= '0;
            end else if (start) begin
               running_ff <= 1'b1;
               cnt_ff     <= '0;
               work_ff    <= PAD_W'(mag);
               acc_ff     <= '0;
               neg_ff     <= sum_next[SUM_W-1];
            end else if (running_ff) begin
               work_ff <= {work_ff[PAD_W-STEPS-1:0], {STEPS{1'b0}}};
               acc_ff  <= acc_v;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(N_CYC - 1)) begin
                  running_ff <= 1'b0;
                  avg_ff     <= neg_ff ? -$signed(quot) : $signed(quot);
               end
            end
         end
      end
   endgenerate

endmodule

// File: hw/rtl/frame_pacer_overshoot_comp_top.sv
// Frame pacer with oversleep compensation.
// Configuration: csr_we writes csr_wdata into the mains period (index 0) or
// the battery period (index 1); a period of zero disables pacing. Write only
// while no beat is in flight.
// Request channel (req_*): tuser carries the beat kind (frame request or
// completion report), tdata the timestamp and the present battery flag.
// Result channel (rsp_*): one beat per request beat; tuser carries the
// action, tdata the granted sleep in nanoseconds.
// A beat accepted into the input register is decided into the result
// register when it advances. One beat is taken every cycle while the result
// register is free and the average is current. With a non-power-of-two ring
// depth, a report that stores an oversleep makes the next beat wait while
// the new average is formed by a sequential reciprocal multiplication; with
// a power-of-two depth there is no wait.
// Reset (synchronous) clears both periods, the timing history, the average
// and all pending state, including any beat or result not yet taken.
// A stalled receiver holds the result register; the input register keeps
// accepting until it is also full, after which req_tready drops.
module frame_pacer_overshoot_comp_top #(
   parameter int RING_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [39:0] csr_wdata,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [61:0] now_time, [62] battery_now, [63] zero
   input  logic [0:0]  req_tuser,   // [0] mode
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [39:0] sleep_time
   output logic [1:0]  rsp_tuser    // [1:0] action
);

   localparam int SUM_W    = fpoc_pkg::OVER_W + $clog2(RING_DEPTH);
   localparam int CALC_W   = fpoc_pkg::CALC_W;
   localparam int TIME_W   = fpoc_pkg::TIME_W;
   localparam int PERIOD_W = fpoc_pkg::PERIOD_W;
   localparam int CHECK_W  = fpoc_pkg::CHECK_W;
   localparam int OVER_W   = fpoc_pkg::OVER_W;

   // Configuration registers
   logic [PERIOD_W-1:0] period_mains_ff;
   logic [PERIOD_W-1:0] period_battery_ff;

   // Input register
   logic                 s1_valid_ff;
   fpoc_pkg::mode_type   s1_mode_ff;
   logic [TIME_W-1:0]    s1_now_ff;
   logic                 s1_batt_ff;

   // Result register
   logic                 rsp_valid_ff;
   fpoc_pkg::action_type rsp_action_ff, rsp_action_in;
   logic [PERIOD_W-1:0]  rsp_sleep_ff, rsp_sleep_in;

   // Pacer state
   logic [TIME_W-1:0]   lft_ff, lft_in;
   logic [CHECK_W-1:0]  next_check_ff, next_check_in;
   logic                on_batt_ff, on_batt_in;
   logic                awaiting_ff, awaiting_in;
   logic                pending_ff, pending_in;
   logic [TIME_W-1:0]   sleep_start_ff, sleep_start_in;
   logic [PERIOD_W-1:0] granted_ff, granted_in;
   logic [PERIOD_W-1:0] frame_period_ff, frame_period_in;

   // Datapath
   logic                     out_free;
   logic                     advance;
   logic                     avg_busy;
   logic signed [SUM_W-1:0]  avg;
   logic signed [SUM_W-1:0]  sum_next;
   logic                     check_due;
   logic                     batt_sel;
   logic [PERIOD_W-1:0]      period_sel;
   logic signed [CALC_W-1:0] adj;
   logic signed [CALC_W-1:0] over;
   logic                     push_req;
   logic signed [OVER_W-1:0] push_value;
   fpoc_pkg::ring_push_type  ring_push;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_mains_ff   <= '0;
         period_battery_ff <= '0;
      end else if (csr_we) begin
         case (fpoc_pkg::csr_index_type'(csr_index))
            fpoc_pkg::REG_PERIOD_MAINS:   period_mains_ff   <= csr_wdata;
            fpoc_pkg::REG_PERIOD_BATTERY: period_battery_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: a beat leaves the input register when the result register
   // is free and the oversleep average is current.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free && !avg_busy;
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_mode_ff <= fpoc_pkg::mode_type'(req_tuser[0]);
         s1_now_ff  <= req_tdata[TIME_W-1:0];
         s1_batt_ff <= req_tdata[TIME_W];
      end
   end

   // Power source and period selection
   always_comb begin
      check_due  = (period_battery_ff != period_mains_ff) &&
                   ({1'b0, s1_now_ff} > next_check_ff);
      batt_sel   = check_due ? s1_batt_ff : on_batt_ff;
      period_sel = batt_sel ? period_battery_ff : period_mains_ff;
   end

   // Remaining period less average oversleep, and the measured oversleep.
   assign adj  = $signed({{(CALC_W - PERIOD_W){1'b0}}, period_sel})
               + $signed({{(CALC_W - TIME_W){1'b0}}, lft_ff})
               - $signed({{(CALC_W - TIME_W){1'b0}}, s1_now_ff})
               - CALC_W'(avg);
   assign over = $signed({{(CALC_W - TIME_W){1'b0}}, s1_now_ff})
               - $signed({{(CALC_W - TIME_W){1'b0}}, sleep_start_ff})
               - $signed({{(CALC_W - PERIOD_W){1'b0}}, granted_ff});

   // Per-beat decision and next state
   always_comb begin
      lft_in          = lft_ff;
      next_check_in   = next_check_ff;
      on_batt_in      = on_batt_ff;
      awaiting_in     = awaiting_ff;
      pending_in      = pending_ff;
      sleep_start_in  = sleep_start_ff;
      granted_in      = granted_ff;
      frame_period_in = frame_period_ff;
      rsp_action_in   = fpoc_pkg::ACT_REPORT_ACK;
      rsp_sleep_in    = '0;
      push_req        = 1'b0;
      push_value      = (over < CALC_W'(fpoc_pkg::OVER_MIN)) ? fpoc_pkg::OVER_MIN
                                                             : over[OVER_W-1:0];
      if (s1_mode_ff == fpoc_pkg::MODE_REQUEST) begin
         if (check_due) begin
            next_check_in = {1'b0, s1_now_ff} + fpoc_pkg::CHECK_INTERVAL;
            on_batt_in    = s1_batt_ff;
         end
         if (period_sel == '0) begin
            rsp_action_in = fpoc_pkg::ACT_DISABLED;
         end else begin
            frame_period_in = period_sel;
            sleep_start_in  = s1_now_ff;
            awaiting_in     = 1'b1;
            if (adj > 0) begin
               granted_in    = (adj > $signed({{(CALC_W - PERIOD_W){1'b0}},
                                               fpoc_pkg::SLEEP_MAX}))
                               ? fpoc_pkg::SLEEP_MAX : adj[PERIOD_W-1:0];
               pending_in    = 1'b1;
               rsp_action_in = fpoc_pkg::ACT_GRANT;
               rsp_sleep_in  = granted_in;
            end else begin
               granted_in    = '0;
               pending_in    = 1'b0;
               rsp_action_in = fpoc_pkg::ACT_NO_SLEEP;
            end
         end
      end else if (awaiting_ff) begin
         // Oversleeps of a full period or more are outliers and are dropped.
         push_req    = pending_ff &&
                       (over < $signed({{(CALC_W - PERIOD_W){1'b0}}, frame_period_ff}));
         lft_in      = s1_now_ff;
         awaiting_in = 1'b0;
         pending_in  = 1'b0;
      end
   end

   assign ring_push = '{push: advance && push_req, value: push_value};

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         lft_ff          <= '0;
         next_check_ff   <= fpoc_pkg::CHECK_INTERVAL;
         on_batt_ff      <= 1'b0;
         awaiting_ff     <= 1'b0;
         pending_ff      <= 1'b0;
         sleep_start_ff  <= '0;
         granted_ff      <= '0;
         frame_period_ff <= '0;
      end else if (advance) begin
         lft_ff          <= lft_in;
         next_check_ff   <= next_check_in;
         on_batt_ff      <= on_batt_in;
         awaiting_ff     <= awaiting_in;
         pending_ff      <= pending_in;
         sleep_start_ff  <= sleep_start_in;
         granted_ff      <= granted_in;
         frame_period_ff <= frame_period_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff <= rsp_action_in;
         rsp_sleep_ff  <= rsp_sleep_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tdata  = rsp_sleep_ff;

   // Oversleep history and its average
   fpoc_ring #(
      .RING_DEPTH (RING_DEPTH),
      .SUM_W      (SUM_W)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ring_push (ring_push),
      .sum_next  (sum_next)
   );

   fpoc_avg #(
      .RING_DEPTH (RING_DEPTH),
      .SUM_W      (SUM_W)
   ) u_avg (
      .clock    (clock),
      .reset    (reset),
      .start    (ring_push.push),
      .sum_next (sum_next),
      .avg      (avg),
      .busy     (avg_busy)
   );

   `include "assert_macros.svh"

   `ASSERT_IMPLIES(a_grant_nonzero, clock, reset, rsp_valid_ff && (rsp_action_ff == fpoc_pkg::ACT_GRANT), rsp_sleep_ff != '0, "granted sleep is zero")
   `ASSERT_IMPLIES(a_sleep_only_grant, clock, reset, rsp_valid_ff && (rsp_action_ff != fpoc_pkg::ACT_GRANT), rsp_sleep_ff == '0, "sleep time on a non-grant result")
   `ASSERT_IMPLIES(a_pending_awaits, clock, reset, pending_ff, awaiting_ff, "sleep pending without an awaited report")
   `ASSERT_IMPLIES(a_stale_average, clock, reset, avg_busy, !advance, "beat processed while average is stale")
   `ASSERT_NEXT(a_result_loaded, clock, reset, advance, rsp_valid_ff, "processed beat produced no result")

endmodule
